FILE: design/asc_pkg.sv
// asc_pkg: shared types, kind codes and signature table for the aligned signature scanner
// no dependencies; used by asc_matcher, asc_reporter and aligned_signature_scanner
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

  localparam int SIG_COUNT_DEF = 8;
  localparam int SIG_SLOTS     = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_SCAN   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } asc_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [31:0] word_address;
    logic        section_first;
  } asc_in_t;

  typedef struct packed {
    logic [2:0]  helper_index;
    logic [31:0] helper_address;
    logic        helper_found;
    logic [3:0]  found_total;
    logic        scan_ok;
    logic        last;
  } asc_out_t;

  // signature length in words, 0 for an unused slot
  function automatic logic [1:0] sig_len(input logic [3:0] slot);
    logic [1:0] len;
    case (slot)
      4'd0, 4'd1, 4'd2, 4'd3: len = 2'd1;
      4'd4, 4'd5, 4'd6, 4'd7: len = 2'd2;
      default:                len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic [31:0] sig_first(input logic [3:0] slot);
    logic [31:0] w;
    case (slot)
      4'd0:       w = 32'hE9C1FF68;
      4'd1:       w = 32'hF9C1FF68;
      4'd2:       w = 32'hC9CCFF70;
      4'd3:       w = 32'hD9CCFF70;
      4'd4, 4'd5: w = 32'h3960FEE0;
      4'd6, 4'd7: w = 32'h3960FC00;
      default:    w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] sig_second(input logic [3:0] slot);
    logic [31:0] w;
    case (slot)
      4'd4:    w = 32'h7DCB60CE;
      4'd5:    w = 32'h7DCB61CE;
      4'd6:    w = 32'h100B60CB;
      4'd7:    w = 32'h100B61CB;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/asc_matcher.sv
// asc_matcher: per-signature first-match tracking and previous-word history
// depends on asc_pkg for the item type, kind codes and signature table
`timescale 1ns / 1ps
`default_nettype none

module asc_matcher #(
  parameter int SIGNATURE_COUNT = asc_pkg::SIG_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go_i,
  input  wire asc_pkg::asc_in_t           item_i,
  output logic [SIGNATURE_COUNT-1:0]      found_o,
  output logic [31:0]                     addr_o [SIGNATURE_COUNT],
  output logic                            any_scanned_o
);

  logic [31:0]                prev_word_r, prev_word_nxt;
  logic [31:0]                prev_addr_r, prev_addr_nxt;
  logic                       prev_valid_r, prev_valid_nxt;
  logic [SIGNATURE_COUNT-1:0] found_r, found_nxt;
  logic [31:0]                addr_r [SIGNATURE_COUNT];
  logic [31:0]                addr_nxt [SIGNATURE_COUNT];
  logic                       any_r, any_nxt;
  logic                       pair_ok;

  always_comb begin
    prev_word_nxt  = prev_word_r;
    prev_addr_nxt  = prev_addr_r;
    prev_valid_nxt = prev_valid_r;
    found_nxt      = found_r;
    addr_nxt       = addr_r;
    any_nxt        = any_r;
    pair_ok        = prev_valid_r && !item_i.section_first;
    if (go_i) begin
      case (item_i.kind)
        asc_pkg::KIND_CLEAR: begin
          prev_valid_nxt = 1'b0;
          found_nxt      = '0;
          any_nxt        = 1'b0;
        end
        asc_pkg::KIND_SCAN: begin
          for (int i = 0; i < SIGNATURE_COUNT; i++) begin
            if (!found_r[i]) begin
              if (asc_pkg::sig_len(4'(i)) == 2'd1 &&
                  item_i.word == asc_pkg::sig_first(4'(i))) begin
                found_nxt[i] = 1'b1;
                addr_nxt[i]  = item_i.word_address;
              end else if (asc_pkg::sig_len(4'(i)) == 2'd2 && pair_ok &&
                           prev_word_r == asc_pkg::sig_first(4'(i)) &&
                           item_i.word == asc_pkg::sig_second(4'(i))) begin
                found_nxt[i] = 1'b1;
                addr_nxt[i]  = prev_addr_r;
              end
            end
          end
          prev_word_nxt  = item_i.word;
          prev_addr_nxt  = item_i.word_address;
          prev_valid_nxt = 1'b1;
          any_nxt        = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      found_r      <= '0;
      any_r        <= 1'b0;
    end else begin
      prev_valid_r <= prev_valid_nxt;
      found_r      <= found_nxt;
      any_r        <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_word_r <= prev_word_nxt;
    prev_addr_r <= prev_addr_nxt;
    addr_r      <= addr_nxt;
  end

  assign found_o       = found_r;
  assign addr_o        = addr_r;
  assign any_scanned_o = any_r;

endmodule

`default_nettype wire

FILE: design/asc_reporter.sv
// asc_reporter: snapshots match state on finish and sends one report line per signature
// depends on asc_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module asc_reporter #(
  parameter int SIGNATURE_COUNT = asc_pkg::SIG_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load_i,
  input  wire logic [SIGNATURE_COUNT-1:0] found_i,
  input  wire logic [31:0]                addr_i [SIGNATURE_COUNT],
  input  wire logic                       any_scanned_i,
  output logic                            can_load_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output asc_pkg::asc_out_t               out_data_o
);

  localparam int IDX_W = (SIGNATURE_COUNT > 1) ? $clog2(SIGNATURE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIGNATURE_COUNT - 1);

  logic                       busy_r, busy_nxt;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;
  logic [SIGNATURE_COUNT-1:0] found_r;
  logic [31:0]                addr_r [SIGNATURE_COUNT];
  logic [3:0]                 total_r;
  logic                       any_r;
  logic                       line_last;
  logic                       line_done;
  logic [4:0]                 cnt_ext;

  assign line_last  = (cnt_r == LAST_IDX);
  assign line_done  = busy_r && out_ready_i;
  assign can_load_o = !busy_r || (line_done && line_last);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (line_done) begin
      if (line_last) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (load_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // snapshot of the match state at the finish transfer
  always_ff @(posedge clk) begin
    if (load_i) begin
      found_r <= found_i;
      addr_r  <= addr_i;
      total_r <= 4'($countones(found_i));
      any_r   <= any_scanned_i;
    end
  end

  always_comb begin
    cnt_ext                     = 5'(cnt_r);
    out_data_o.helper_index     = cnt_ext[2:0];
    out_data_o.helper_found     = found_r[cnt_r];
    out_data_o.helper_address   = found_r[cnt_r] ? addr_r[cnt_r] : 32'h0;
    out_data_o.found_total      = total_r;
    out_data_o.scan_ok          = any_r;
    out_data_o.last             = line_last;
  end

  assign out_valid_o = busy_r;

endmodule

`default_nettype wire

FILE: design/aligned_signature_scanner.sv
// channel  | ports                          | moves
// input    | in_valid in_ready in_data      | clear, scan word or finish item
// result   | out_valid out_ready out_data   | one report line per signature
//
// each item is held in the input register; a scan updates the match state there
// clear and scan transfers sustain one per cycle unless a finish waits; a finish emits SIGNATURE_COUNT lines,
// one per cycle while out_ready is high, and scans keep flowing meanwhile
// a second finish waits in the input register until the last line of the first transfers
// rst_n is synchronous; reset clears found flags, history valid and the report sequencer
`timescale 1ns / 1ps
`default_nettype none

module aligned_signature_scanner #(
  parameter int SIGNATURE_COUNT = asc_pkg::SIG_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire asc_pkg::asc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output asc_pkg::asc_out_t     out_data
);

  logic                       stg_valid_r, stg_valid_nxt;
  asc_pkg::asc_in_t           stg_item_r;
  logic                       stg_go;
  logic                       stg_finish;
  logic                       rep_load;
  logic                       rep_can_load;
  logic [SIGNATURE_COUNT-1:0] found;
  logic [31:0]                addr [SIGNATURE_COUNT];
  logic                       any_scanned;

  assign stg_finish = (stg_item_r.kind == asc_pkg::KIND_FINISH);
  assign stg_go     = stg_valid_r && (!stg_finish || rep_can_load);
  assign rep_load   = stg_go && stg_finish;
  assign in_ready   = !stg_valid_r || stg_go;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_ready) begin
      stg_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_item_r <= in_data;
    end
  end

  asc_matcher #(
    .SIGNATURE_COUNT(SIGNATURE_COUNT)
  ) u_matcher (
    .clk           (clk),
    .rst_n         (rst_n),
    .go_i          (stg_go),
    .item_i        (stg_item_r),
    .found_o       (found),
    .addr_o        (addr),
    .any_scanned_o (any_scanned)
  );

  asc_reporter #(
    .SIGNATURE_COUNT(SIGNATURE_COUNT)
  ) u_reporter (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_i        (rep_load),
    .found_i       (found),
    .addr_i        (addr),
    .any_scanned_i (any_scanned),
    .can_load_o    (rep_can_load),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_o    (out_data)
  );

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report line valid right after reset");

  a_unfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.helper_found |-> out_data.helper_address == 32'h0)
    else $error("address reported for unmatched signature");

  a_found_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.scan_ok |-> !out_data.helper_found)
    else $error("match reported with no word scanned");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    rep_load |-> !out_valid || (out_ready && out_data.last))
    else $error("finish taken while a report is still in flight");
`endif

endmodule

`default_nettype wire
